[rtl/core/ple_pkg.sv]
// Package for the positional list engine.
// Holds the field widths, request kind and status codes, and the controller command.
// No dependencies.
`default_nettype none

package ple_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int KIND_WIDTH   = 3;
   localparam int VALUE_WIDTH  = 32;
   localparam int POS_WIDTH    = 8;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_INS_HEAD = 3'd0,
      KIND_INS_TAIL = 3'd1,
      KIND_INS_POS  = 3'd2,
      KIND_DEL_HEAD = 3'd3,
      KIND_DEL_TAIL = 3'd4,
      KIND_DEL_POS  = 3'd5
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_INS  = 2'd1,
      OP_DEL  = 2'd2
   } op_type;

   typedef struct packed {
      logic                 load;
      logic                 exec;
      op_type               op;
      status_type           status;
      logic [POS_WIDTH-1:0] slot;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/core/ple_if.sv]
// Request and response channel interfaces for the positional list engine.
// Depends on ple_pkg for the field widths.
`default_nettype none

interface ple_req_if
   import ple_pkg::*;
   ();
   logic                          valid;
   logic                          ready;
   logic [KIND_WIDTH-1:0]         kind;
   logic signed [VALUE_WIDTH-1:0] value;
   logic [POS_WIDTH-1:0]          position;

   modport source (output valid, output kind, output value, output position, input ready);
   modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface ple_rsp_if
   import ple_pkg::*;
   #(parameter int COUNT_WIDTH = $clog2(CAPACITY_DEF + 1))
   ();
   logic                          valid;
   logic                          ready;
   logic [STATUS_WIDTH-1:0]       status;
   logic [COUNT_WIDTH-1:0]        length;
   logic                          first_valid;
   logic signed [VALUE_WIDTH-1:0] first_value;

   modport source (output valid, output status, output length, output first_valid,
                   output first_value, input ready);
   modport sink   (input valid, input status, input length, input first_valid,
                   input first_value, output ready);
endinterface

`default_nettype wire

[rtl/core/ple_ctrl.sv]
// Controller for the positional list engine: handshakes and request decode.
// Depends on ple_pkg; drives the command into ple_datapath.
`default_nettype none

module ple_ctrl
   import ple_pkg::*;
   #(parameter int CAPACITY = CAPACITY_DEF,
     localparam int CW = $clog2(CAPACITY + 1))
   (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [KIND_WIDTH-1:0] req_kind,
   input  wire logic [POS_WIDTH-1:0]  req_position,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [CW-1:0]         count,
   output cmd_type                    cmd
   );

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                state_ff;
   kind_type                 kind_ff;
   logic [POS_WIDTH-1:0]     pos_ff;
   logic                     rsp_valid_ff;

   logic                     accept;
   logic                     full;
   logic                     empty;
   logic [POS_WIDTH:0]       pos_ext;
   logic [POS_WIDTH:0]       cnt_ext;
   logic                     past_end;
   logic [POS_WIDTH-1:0]     slot_pos;
   logic [POS_WIDTH-1:0]     slot_tail;
   logic [POS_WIDTH-1:0]     slot_last;
   op_type                   op;
   status_type               status;
   logic [POS_WIDTH-1:0]     slot;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign full      = (count == CW'(CAPACITY));
   assign empty     = (count == '0);
   assign pos_ext   = {1'b0, pos_ff};
   assign cnt_ext   = (POS_WIDTH + 1)'(count);
   assign past_end  = (pos_ext > cnt_ext);
   assign slot_pos  = pos_ff - POS_WIDTH'(1);
   assign slot_tail = POS_WIDTH'(count);
   assign slot_last = POS_WIDTH'(count) - POS_WIDTH'(1);

   always_comb begin
      op     = OP_NONE;
      status = STATUS_OK;
      slot   = '0;
      case (kind_ff)
         KIND_INS_HEAD: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               op = OP_INS;
            end
         end
         KIND_INS_TAIL: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               op   = OP_INS;
               slot = slot_tail;
            end
         end
         KIND_INS_POS: begin
            if (full) begin
               status = STATUS_FULL;
            end else if (pos_ff != '0) begin
               op   = OP_INS;
               slot = past_end ? slot_tail : slot_pos;
            end
         end
         KIND_DEL_HEAD: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               op = OP_DEL;
            end
         end
         KIND_DEL_TAIL: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               op   = OP_DEL;
               slot = slot_last;
            end
         end
         KIND_DEL_POS: begin
            if (pos_ff == '0) begin
               status = STATUS_OK;
            end else if (pos_ff == POS_WIDTH'(1)) begin
               if (empty) begin
                  status = STATUS_EMPTY;
               end else begin
                  op = OP_DEL;
               end
            end else if (past_end) begin
               status = STATUS_RANGE;
            end else begin
               op   = OP_DEL;
               slot = slot_pos;
            end
         end
         default: begin
            op = OP_NONE;
         end
      endcase
   end

   assign cmd.load   = accept;
   assign cmd.exec   = (state_ff == ST_EXEC);
   assign cmd.op     = op;
   assign cmd.status = status;
   assign cmd.slot   = slot;

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_type'(req_kind);
         pos_ff  <= req_position;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("request accepted but not executed");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> rsp_valid_ff)
      else $error("execution produced no response beat");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_valid_ff || rsp_ready)
      else $error("request accepted over a stalled response");
`endif

endmodule

`default_nettype wire

[rtl/core/ple_datapath.sv]
// Datapath for the positional list engine: entry shift chain, length and response register.
// Depends on ple_pkg; takes commands from ple_ctrl.
`default_nettype none

module ple_datapath
   import ple_pkg::*;
   #(parameter int CAPACITY = CAPACITY_DEF,
     localparam int CW = $clog2(CAPACITY + 1))
   (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   output logic [CW-1:0]                      count,
   output logic [STATUS_WIDTH-1:0]            rsp_status,
   output logic [CW-1:0]                      rsp_length,
   output logic                               rsp_first_valid,
   output logic signed [VALUE_WIDTH-1:0]      rsp_first_value
   );

   logic [VALUE_WIDTH-1:0]    entries_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0]    entries_in [CAPACITY];
   logic [VALUE_WIDTH-1:0]    value_ff;
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic [STATUS_WIDTH-1:0]   status_ff;
   logic [CW-1:0]             length_ff;
   logic                      first_valid_ff;
   logic [VALUE_WIDTH-1:0]    first_value_ff;
   logic                      write;

   assign write = cmd.exec && (cmd.op != OP_NONE);

   for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
      logic [VALUE_WIDTH-1:0] prev;
      logic [VALUE_WIDTH-1:0] next;
      logic                   below;
      logic                   at;

      if (g == 0) begin : g_head
         assign prev = value_ff;
      end else begin : g_body
         assign prev = entries_ff[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next = entries_ff[g];
      end else begin : g_inner
         assign next = entries_ff[g+1];
      end

      assign below = (POS_WIDTH'(g) < cmd.slot);
      assign at    = (POS_WIDTH'(g) == cmd.slot);

      always_comb begin
         entries_in[g] = entries_ff[g];
         case (cmd.op)
            OP_INS: begin
               if (at) begin
                  entries_in[g] = value_ff;
               end else if (!below) begin
                  entries_in[g] = prev;
               end
            end
            OP_DEL: begin
               if (!below) begin
                  entries_in[g] = next;
               end
            end
            default: begin
               entries_in[g] = entries_ff[g];
            end
         endcase
      end
   end

   always_comb begin
      case (cmd.op)
         OP_INS:  count_in = count_ff + CW'(1);
         OP_DEL:  count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   assign count           = count_ff;
   assign rsp_status      = status_ff;
   assign rsp_length      = length_ff;
   assign rsp_first_valid = first_valid_ff;
   assign rsp_first_value = first_value_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
      end
      if (write) begin
         entries_ff <= entries_in;
      end
      if (cmd.exec) begin
         status_ff      <= cmd.status;
         length_ff      <= count_in;
         first_valid_ff <= (count_in != '0);
         first_value_ff <= (count_in != '0) ? entries_in[0] : '0;
      end
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("length exceeds capacity");

   a_count_reset: assert property (@(posedge clock)
      reset |=> count_ff == '0)
      else $error("length not cleared by reset");

   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && cmd.op == OP_INS |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   a_del_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && cmd.op == OP_DEL |=> count_ff == $past(count_ff) - CW'(1))
      else $error("delete did not shrink the list");
`endif

endmodule

`default_nettype wire

[rtl/core/positional_list_engine.sv]
// Positional list engine: an accepted request passes through the controller's execute state
// before its registered response beat; no new request is taken until the controller is idle.
// A response beat may stall; the next request is taken in the cycle that beat leaves.
// Reset clears the length and the handshake state; the list reads empty at once.
// Entry storage is not cleared and is never read past the length.
`default_nettype none

module positional_list_engine
   import ple_pkg::*;
   #(parameter int CAPACITY = CAPACITY_DEF,
     localparam int CW = $clog2(CAPACITY + 1))
   (
   input  wire logic  clock,
   input  wire logic  reset,
   ple_req_if.sink    req_bus,
   ple_rsp_if.source  rsp_bus
   );

   cmd_type                       cmd;
   logic [CW-1:0]                 count;
   logic                          req_ready;
   logic                          rsp_valid;
   logic [STATUS_WIDTH-1:0]       rsp_status;
   logic [CW-1:0]                 rsp_length;
   logic                          rsp_first_valid;
   logic signed [VALUE_WIDTH-1:0] rsp_first_value;

   ple_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_ready    (req_ready),
      .req_kind     (req_bus.kind),
      .req_position (req_bus.position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_bus.ready),
      .count        (count),
      .cmd          (cmd)
   );

   ple_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_value       (req_bus.value),
      .count           (count),
      .rsp_status      (rsp_status),
      .rsp_length      (rsp_length),
      .rsp_first_valid (rsp_first_valid),
      .rsp_first_value (rsp_first_value)
   );

   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.status      = rsp_status;
   assign rsp_bus.length      = rsp_length;
   assign rsp_bus.first_valid = rsp_first_valid;
   assign rsp_bus.first_value = rsp_first_value;

endmodule

`default_nettype wire

[bench/tb_positional_list_engine.sv]
// Self-checking bench for positional_list_engine: directed corner requests, then random
// fill/drain/mix phases, with random idling on both channels and a long response hold-off.
// Depends on ple_pkg and the ple_req_if / ple_rsp_if interfaces.
`default_nettype none

module tb_positional_list_engine;
   import ple_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH   = CAPACITY_DEF;
   localparam int LEN_WIDTH    = $clog2(CAPACITY_DEF + 1);
   localparam int RANDOM_ITEMS = 1400;

   typedef struct {
      kind_type                      kind;
      logic signed [VALUE_WIDTH-1:0] value;
      logic [POS_WIDTH-1:0]          position;
   } list_req_type;

   typedef struct {
      status_type                    status;
      logic [LEN_WIDTH-1:0]          length;
      logic                          first_valid;
      logic signed [VALUE_WIDTH-1:0] first_value;
   } list_rsp_type;

   logic clock;
   logic reset;

   ple_req_if req_bus ();
   ple_rsp_if rsp_bus ();

   positional_list_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   list_req_type                  pending_req[$];
   list_rsp_type                  expected_rsp[$];
   logic signed [VALUE_WIDTH-1:0] list_mirror[$];
   int                            mismatch_count = 0;
   int                            accepted_total = 0;
   int                            received_total = 0;
   int                            send_gap       = 0;
   int                            recv_stall     = 0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic list_rsp_type apply_list_op(input list_req_type req);
      list_rsp_type r;
      int           count;
      count    = list_mirror.size();
      r.status = STATUS_OK;
      case (req.kind)
         KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_POS: begin
            if (count >= LIST_DEPTH)
               r.status = STATUS_FULL;
            else if (req.kind == KIND_INS_HEAD)
               list_mirror.push_front(req.value);
            else if (req.kind == KIND_INS_TAIL || req.position > count)
               list_mirror.push_back(req.value);
            else if (req.position != 0)
               list_mirror.insert(req.position - 1, req.value);
         end
         KIND_DEL_HEAD, KIND_DEL_TAIL: begin
            if (count == 0)
               r.status = STATUS_EMPTY;
            else if (req.kind == KIND_DEL_HEAD)
               void'(list_mirror.pop_front());
            else
               void'(list_mirror.pop_back());
         end
         KIND_DEL_POS: begin
            if (req.position == 0)
               r.status = STATUS_OK;
            else if (req.position == 1 && count == 0)
               r.status = STATUS_EMPTY;
            else if (req.position > count)
               r.status = STATUS_RANGE;
            else
               list_mirror.delete(req.position - 1);
         end
         default: ;
      endcase
      r.length      = LEN_WIDTH'(list_mirror.size());
      r.first_valid = (list_mirror.size() != 0);
      r.first_value = (list_mirror.size() != 0) ? list_mirror[0] : '0;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0d ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   task automatic add_req(input kind_type kind, input logic signed [VALUE_WIDTH-1:0] value,
                          input logic [POS_WIDTH-1:0] position);
      list_req_type req;
      req.kind     = kind;
      req.value    = value;
      req.position = position;
      pending_req.push_back(req);
   endtask

   // request driver
   always @(posedge clock) begin
      list_req_type req;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid) begin
            req.kind     = kind_type'(req_bus.kind);
            req.value    = req_bus.value;
            req.position = req_bus.position;
            expected_rsp.push_back(apply_list_op(req));
            accepted_total++;
            send_gap = (accepted_total % 400 >= 300) ? 0 : $urandom_range(0, 3);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_req.size() != 0) begin
            req = pending_req.pop_front();
            req_bus.kind     <= req.kind;
            req_bus.value    <= req.value;
            req_bus.position <= req.position;
            req_bus.valid    <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      list_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            received_total++;
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               $display("%0d ns: unexpected beat, expected none actual status %0d length %0d",
                        $time, rsp_bus.status, rsp_bus.length);
            end else begin
               want = expected_rsp.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_bus.status));
               check_field("length", 32'(want.length), 32'(rsp_bus.length));
               check_field("first_valid", 32'(want.first_valid), 32'(rsp_bus.first_valid));
               check_field("first_value", want.first_value, rsp_bus.first_value);
            end
            if (received_total == 300 || received_total == 1000)
               recv_stall = 60;
            else
               recv_stall = (received_total % 500 >= 400) ? 0 : $urandom_range(0, 3);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int                            planned_total;
      int                            phase_len;
      int                            insert_pct;
      int                            mode;
      kind_type                      kind;
      logic signed [VALUE_WIDTH-1:0] value;
      logic [POS_WIDTH-1:0]          position;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_INS_HEAD;
      req_bus.value    = '0;
      req_bus.position = '0;
      rsp_bus.ready    = 1'b0;

      // empty-list corners
      add_req(KIND_DEL_HEAD, 32'sh0, 8'd0);
      add_req(KIND_DEL_TAIL, 32'sh0, 8'd0);
      add_req(KIND_DEL_POS, 32'sh0, 8'd1);
      add_req(KIND_DEL_POS, 32'sh0, 8'd2);
      add_req(KIND_DEL_POS, 32'sh0, 8'd0);
      add_req(KIND_DEL_POS, 32'sh0, 8'd255);
      add_req(KIND_INS_POS, 32'sh1234, 8'd0);
      // build up through every insert form
      add_req(KIND_INS_HEAD, 32'sh80000000, 8'd0);
      add_req(KIND_INS_TAIL, 32'sh7FFFFFFF, 8'd0);
      add_req(KIND_INS_POS, -32'sd1, 8'd1);
      add_req(KIND_INS_POS, 32'sh0, 8'd255);
      add_req(KIND_INS_POS, 32'sh5A5A5A5A, 8'd2);
      add_req(KIND_INS_POS, 32'shA5A5A5A5, 8'd4);
      // tear down through every delete form, down past a single entry
      add_req(KIND_DEL_POS, 32'sh0, 8'd255);
      add_req(KIND_DEL_POS, 32'sh0, 8'd7);
      add_req(KIND_DEL_POS, 32'sh0, 8'd6);
      add_req(KIND_DEL_POS, 32'sh0, 8'd3);
      add_req(KIND_DEL_TAIL, 32'sh0, 8'd0);
      add_req(KIND_DEL_HEAD, 32'sh0, 8'd0);
      add_req(KIND_DEL_POS, 32'sh0, 8'd1);
      add_req(KIND_DEL_TAIL, 32'sh0, 8'd0);
      add_req(KIND_INS_TAIL, 32'sh13579BDF, 8'd0);
      add_req(KIND_DEL_TAIL, 32'sh0, 8'd0);
      add_req(KIND_INS_POS, 32'sh2468ACE0, 8'd5);
      add_req(KIND_DEL_POS, 32'sh0, 8'd1);

      // fill, drain and mixed phases so the list keeps hitting full and empty
      planned_total = pending_req.size() + RANDOM_ITEMS;
      while (pending_req.size() < planned_total) begin
         phase_len  = $urandom_range(20, 60);
         mode       = $urandom_range(0, 2);
         insert_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
         for (int i = 0; i < phase_len && pending_req.size() < planned_total; i++) begin
            if ($urandom_range(0, 99) < insert_pct)
               kind = kind_type'($urandom_range(0, 2));
            else
               kind = kind_type'($urandom_range(3, 5));
            case ($urandom_range(0, 7))
               0:       value = 32'sh80000000;
               1:       value = 32'sh7FFFFFFF;
               2:       value = 32'sh0;
               3:       value = -32'sd1;
               default: value = $urandom;
            endcase
            if ($urandom_range(0, 4) == 0)
               position = POS_WIDTH'($urandom_range(0, 255));
            else
               position = POS_WIDTH'($urandom_range(0, LIST_DEPTH + 2));
            add_req(kind, value, position);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_total < planned_total || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatch_count == 0 && expected_rsp.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
